[rtl/record_field_stream_parser_unit_assert.svh]
// Assertion macros for the checker file of the record parser.
// No dependencies; clk and arst_n must be visible where a macro is used.
`ifndef RECORD_FIELD_STREAM_PARSER_UNIT_ASSERT_SVH
`define RECORD_FIELD_STREAM_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RFSP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RFSP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/rfsp_pkg.sv]
// Shared constants, types and the varint group step for the record parser.
// No dependencies.
package rfsp_pkg;

	localparam int LENGTH_BITS = 32;
	localparam int SEQ_BYTES   = 7;
	localparam int SEQ_W       = SEQ_BYTES * 8;
	localparam int MAX_GROUPS  = (LENGTH_BITS + 6) / 7;
	localparam int GRP_W       = $clog2(MAX_GROUPS + 1);
	localparam int CNT_W       = (LENGTH_BITS > 8) ? LENGTH_BITS : 8;
	localparam int WIDE_W      = LENGTH_BITS + 7;
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);

	typedef enum logic [2:0] {
		KIND_KEYLEN = 3'd0,
		KIND_KEY    = 3'd1,
		KIND_SEQ    = 3'd2,
		KIND_TYPE   = 3'd3,
		KIND_VARINT = 3'd4,
		KIND_VALUE  = 3'd5
	} kind_t;

	// One classified item handed from front to back.
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic        done;
		logic        last;
	} entry_t;

	typedef struct packed {
		logic [LENGTH_BITS-1:0] acc;
		logic [GRP_W-1:0]       grp;
		logic                   err;
	} varint_t;

	// Fold one base-128 group into the accumulator; flag groups past the
	// limit and payload bits above LENGTH_BITS.
	function automatic varint_t varint_step(input logic [LENGTH_BITS-1:0] acc,
			input logic [GRP_W-1:0] grp, input logic [7:0] b);
		varint_t            r;
		logic [WIDE_W-1:0]  wide;
		r.acc = acc;
		r.grp = grp;
		r.err = 1'b0;
		wide  = '0;
		if (grp >= GRP_W'(MAX_GROUPS)) begin
			r.err = 1'b1;
		end else begin
			wide  = WIDE_W'(b[6:0]) << (7 * int'(grp));
			r.acc = acc | wide[LENGTH_BITS-1:0];
			r.err = |wide[WIDE_W-1:LENGTH_BITS];
			r.grp = grp + 1'b1;
		end
		return r;
	endfunction

endpackage

[rtl/record_field_stream_parser_unit.sv]
// Record parser top level: one result per input byte, one byte per cycle sustained while full stays low.
// Path: an accepted byte is classified combinationally, written into the queue, then registered.
// Throughput: 1 byte/cycle while full is low, set by the front phase/count register, which resolves each
// byte as it is accepted; a 4-entry queue and the result register absorb output stalls.
// Reset: arst_n clears phase, counts, header fields and the queue; empty reads high.
// Depends on rfsp_pkg, rfsp_front, rfsp_queue, rfsp_back.
module record_field_stream_parser_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic [7:0]                         data_byte,
	output logic                               empty,
	input  logic                               pop,
	output logic [2:0]                         field_kind,
	output logic [7:0]                         byte_out,
	output logic [7:0]                         key_length,
	output logic [rfsp_pkg::SEQ_W-1:0]         sequence_number,
	output logic [7:0]                         record_type,
	output logic [rfsp_pkg::LENGTH_BITS-1:0]   value_length,
	output logic                               header_done,
	output logic                               record_last,
	output logic                               length_error
);
	import rfsp_pkg::*;

	entry_t front_entry, q_entry;
	logic   accept, q_valid, q_rd;

	assign accept = push && !full;

	rfsp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.entry     (front_entry)
	);

	rfsp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (accept),
		.wr_entry (front_entry),
		.full     (full),
		.rd       (q_rd),
		.rd_entry (q_entry),
		.nonempty (q_valid)
	);

	rfsp_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_entry         (q_entry),
		.q_rd            (q_rd),
		.empty           (empty),
		.pop             (pop),
		.field_kind      (field_kind),
		.byte_out        (byte_out),
		.key_length      (key_length),
		.sequence_number (sequence_number),
		.record_type     (record_type),
		.value_length    (value_length),
		.header_done     (header_done),
		.record_last     (record_last),
		.length_error    (length_error)
	);

endmodule

[rtl/rfsp_front.sv]
// Front part: tracks the record phase and byte counts and classifies each byte.
// Depends on rfsp_pkg.
module rfsp_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [7:0]      data_byte,
	output rfsp_pkg::entry_t entry
);
	import rfsp_pkg::*;

	typedef enum logic [2:0] {
		PH_KEYLEN = 3'd0,
		PH_KEY    = 3'd1,
		PH_SEQ    = 3'd2,
		PH_TYPE   = 3'd3,
		PH_VARINT = 3'd4,
		PH_VALUE  = 3'd5
	} phase_t;

	phase_t                 phase_q, phase_d;
	logic [CNT_W-1:0]       left_q, left_d;
	logic [GRP_W-1:0]       grp_q, grp_d;
	logic [LENGTH_BITS-1:0] acc_q, acc_d;
	varint_t                vstep;

	assign vstep = varint_step(acc_q, grp_q, data_byte);

	always_comb begin
		phase_d    = phase_q;
		left_d     = left_q;
		grp_d      = grp_q;
		acc_d      = acc_q;
		entry.data = data_byte;
		entry.kind = KIND_KEYLEN;
		entry.done = 1'b0;
		entry.last = 1'b0;
		unique case (phase_q)
			PH_KEY: begin
				entry.kind = KIND_KEY;
				left_d     = left_q - 1'b1;
				if (left_q == CNT_W'(1)) begin
					phase_d = PH_SEQ;
					left_d  = CNT_W'(SEQ_BYTES);
				end
			end
			PH_SEQ: begin
				entry.kind = KIND_SEQ;
				left_d     = left_q - 1'b1;
				if (left_q == CNT_W'(1)) phase_d = PH_TYPE;
			end
			PH_TYPE: begin
				entry.kind = KIND_TYPE;
				phase_d    = PH_VARINT;
				grp_d      = '0;
				acc_d      = '0;
			end
			PH_VARINT: begin
				entry.kind = KIND_VARINT;
				grp_d      = vstep.grp;
				acc_d      = vstep.acc;
				if (!data_byte[7]) begin
					entry.done = 1'b1;
					left_d     = CNT_W'(vstep.acc);
					if (vstep.acc == '0) begin
						entry.last = 1'b1;
						phase_d    = PH_KEYLEN;
					end else begin
						phase_d = PH_VALUE;
					end
				end
			end
			PH_VALUE: begin
				entry.kind = KIND_VALUE;
				left_d     = left_q - 1'b1;
				if (left_q == CNT_W'(1)) begin
					entry.last = 1'b1;
					phase_d    = PH_KEYLEN;
				end
			end
			default: begin
				// key length byte; unused phase codes land here too
				entry.kind = KIND_KEYLEN;
				grp_d      = '0;
				acc_d      = '0;
				if (data_byte == 8'd0) begin
					phase_d = PH_SEQ;
					left_d  = CNT_W'(SEQ_BYTES);
				end else begin
					phase_d = PH_KEY;
					left_d  = CNT_W'(data_byte);
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_KEYLEN;
			left_q  <= '0;
			grp_q   <= '0;
			acc_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			left_q  <= left_d;
			grp_q   <= grp_d;
			acc_q   <= acc_d;
		end
	end

endmodule

[rtl/rfsp_queue.sv]
// Short queue of classified items between the front and back parts.
// Depends on rfsp_pkg.
module rfsp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  rfsp_pkg::entry_t wr_entry,
	output logic             full,
	input  logic             rd,
	output rfsp_pkg::entry_t rd_entry,
	output logic             nonempty
);
	import rfsp_pkg::*;

	entry_t            slot_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_wr, do_rd;

	assign full     = (cnt_q == QCNT_W'(QDEPTH));
	assign nonempty = (cnt_q != '0);
	assign do_wr    = wr && !full;
	assign do_rd    = rd && nonempty;
	assign rd_entry = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) slot_q[wptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) wptr_q <= wptr_q + 1'b1;
			if (do_rd) rptr_q <= rptr_q + 1'b1;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

[rtl/rfsp_back.sv]
// Back part: assembles header fields from classified items into a result register.
// Depends on rfsp_pkg.
module rfsp_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_valid,
	input  rfsp_pkg::entry_t                   q_entry,
	output logic                               q_rd,
	output logic                               empty,
	input  logic                               pop,
	output logic [2:0]                         field_kind,
	output logic [7:0]                         byte_out,
	output logic [7:0]                         key_length,
	output logic [rfsp_pkg::SEQ_W-1:0]         sequence_number,
	output logic [7:0]                         record_type,
	output logic [rfsp_pkg::LENGTH_BITS-1:0]   value_length,
	output logic                               header_done,
	output logic                               record_last,
	output logic                               length_error
);
	import rfsp_pkg::*;

	logic [7:0]             key_q, key_d;
	logic [SEQ_W-1:0]       seq_q, seq_d;
	logic [7:0]             type_q, type_d;
	logic [LENGTH_BITS-1:0] acc_q, acc_d;
	logic [GRP_W-1:0]       grp_q, grp_d;
	logic                   err_q, err_d;
	varint_t                vstep;

	logic                   out_valid_q;
	kind_t                  kind_q;
	logic [7:0]             byte_q, okey_q, otype_q;
	logic [SEQ_W-1:0]       oseq_q;
	logic [LENGTH_BITS-1:0] olen_q;
	logic                   done_q, last_q, oerr_q;

	assign q_rd  = q_valid && (!out_valid_q || pop);
	assign vstep = varint_step(acc_q, grp_q, q_entry.data);

	always_comb begin
		key_d  = key_q;
		seq_d  = seq_q;
		type_d = type_q;
		acc_d  = acc_q;
		grp_d  = grp_q;
		err_d  = err_q;
		unique case (q_entry.kind)
			KIND_KEYLEN: begin
				key_d  = q_entry.data;
				seq_d  = '0;
				type_d = '0;
				acc_d  = '0;
				grp_d  = '0;
				err_d  = 1'b0;
			end
			KIND_SEQ: seq_d = SEQ_W'({seq_q, q_entry.data});
			KIND_TYPE: begin
				type_d = q_entry.data;
				acc_d  = '0;
				grp_d  = '0;
			end
			KIND_VARINT: begin
				acc_d = vstep.acc;
				grp_d = vstep.grp;
				err_d = err_q | vstep.err;
			end
			default: ; // key and value bytes leave the header alone
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q       <= '0;
			seq_q       <= '0;
			type_q      <= '0;
			acc_q       <= '0;
			grp_q       <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_rd) begin
				key_q  <= key_d;
				seq_q  <= seq_d;
				type_q <= type_d;
				acc_q  <= acc_d;
				grp_q  <= grp_d;
				err_q  <= err_d;
			end
			if (q_rd) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
		end
	end

	// Result register: payload only, qualified by out_valid_q.
	always_ff @(posedge clk) begin
		if (q_rd) begin
			kind_q  <= q_entry.kind;
			byte_q  <= q_entry.data;
			okey_q  <= key_d;
			oseq_q  <= seq_d;
			otype_q <= type_d;
			olen_q  <= acc_d;
			done_q  <= q_entry.done;
			last_q  <= q_entry.last;
			oerr_q  <= err_d;
		end
	end

	assign empty           = !out_valid_q;
	assign field_kind      = kind_q;
	assign byte_out        = byte_q;
	assign key_length      = okey_q;
	assign sequence_number = oseq_q;
	assign record_type     = otype_q;
	assign value_length    = olen_q;
	assign header_done     = done_q;
	assign record_last     = last_q;
	assign length_error    = oerr_q;

endmodule

[rtl/rfsp_checker.sv]
// Port-level checker for the record parser, bound to the top level.
// Depends on rfsp_pkg and record_field_stream_parser_unit_assert.svh.
`include "record_field_stream_parser_unit_assert.svh"

module rfsp_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               empty,
	input logic                               pop,
	input logic [2:0]                         field_kind,
	input logic [7:0]                         byte_out,
	input logic [rfsp_pkg::SEQ_W-1:0]         sequence_number,
	input logic [7:0]                         record_type,
	input logic [rfsp_pkg::LENGTH_BITS-1:0]   value_length,
	input logic                               header_done,
	input logic                               record_last,
	input logic                               length_error
);
	import rfsp_pkg::*;

	// header_done only on a varint byte
	`RFSP_ASSERT_NOW(a_done_on_varint, !empty && header_done, field_kind == KIND_VARINT,
		"header_done off a varint byte")

	// a record ends on a value byte or on a final varint byte
	`RFSP_ASSERT_NOW(a_last_kind, !empty && record_last,
		(field_kind == KIND_VALUE) || (field_kind == KIND_VARINT && header_done),
		"record_last on wrong byte")

	// a key length byte starts with clean header fields
	`RFSP_ASSERT_NOW(a_keylen_clears, !empty && field_kind == KIND_KEYLEN,
		!length_error && record_type == 8'd0 && value_length == '0 && sequence_number == '0,
		"key length byte did not clear header")

	// a waiting result holds until it is popped
	`RFSP_ASSERT_NEXT(a_hold, !empty && !pop,
		!empty && $stable(byte_out) && $stable(field_kind), "waiting result changed")

endmodule

bind record_field_stream_parser_unit rfsp_checker u_rfsp_checker (.*);
